[src/fprx_pkg.sv]
// Shared types, constants and the CRC step function of the framed packet receiver.
`default_nettype none

package fprx_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SYNC_FIRST       = 3'd0;
    localparam logic [2:0] CFG_SYNC_SECOND      = 3'd1;
    localparam logic [2:0] CFG_PROTOCOL_VERSION = 3'd2;
    localparam logic [2:0] CFG_TYPE_VELOCITY    = 3'd3;
    localparam logic [2:0] CFG_TYPE_STOP        = 3'd4;
    localparam logic [2:0] CFG_TYPE_CLEAR_STOP  = 3'd5;
    localparam logic [2:0] CFG_TYPE_STATUS      = 3'd6;

    // Configuration reset values
    localparam logic [7:0] RST_SYNC_FIRST       = 8'hAA;
    localparam logic [7:0] RST_SYNC_SECOND      = 8'h55;
    localparam logic [7:0] RST_PROTOCOL_VERSION = 8'h01;
    localparam logic [7:0] RST_TYPE_VELOCITY    = 8'h01;
    localparam logic [7:0] RST_TYPE_STOP        = 8'h02;
    localparam logic [7:0] RST_TYPE_CLEAR_STOP  = 8'h03;
    localparam logic [7:0] RST_TYPE_STATUS      = 8'h04;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Only velocity frames carry payload, and always exactly this many bytes
    localparam int         RUN_MAX   = 8;
    localparam int         RUN_IDX_W = 3;
    localparam logic [6:0] VEL_LEN   = 7'd8;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] protocol_version;
        logic [7:0] type_velocity;
        logic [7:0] type_stop;
        logic [7:0] type_clear_stop;
        logic [7:0] type_status;
    } t_cfg;

    typedef struct packed {
        logic [31:0] resyncs;
        logic [31:0] crc_failures;
        logic [31:0] unknown_types;
        logic [31:0] sequence_gaps;
    } t_counters;

    typedef struct packed {
        logic                      kind;
        logic [7:0]                ftype;
        logic [6:0]                flen;
        logic [15:0]               fseq;
        logic [RUN_MAX-1:0][7:0]   payload;
        t_counters                 cnt;
    } t_job;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/framed_packet_receiver_crc16.sv]
// Top level of the framed packet receiver with CRC-16 check.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ---------------------------------------------
//  rx byte   in         i_valid / o_ready    i_rx_byte
//  result    out        o_valid / i_ready    o_record_kind .. o_sequence_gaps (11 fields)
//  config    in         i_cfg_we (no wait)   i_cfg_index, i_cfg_data
//
// The parser takes one byte per cycle while the two-entry job queue has room.
// Each accepted byte pushes one job, registered in the queue and shown once the
// jobs ahead of it are played out; a status result is a single transaction, an
// accepted velocity frame a run of eight records, while the parser keeps running
// until the queue fills. Reset (synchronous, active low) empties the queue and
// restores all registers but the job and payload storage. A stall on the output
// holds the current record and, once the queue is full, drops o_ready.
`default_nettype none

module framed_packet_receiver_crc16 #(
    parameter int MAX_PAYLOAD = 64,
    parameter int MAX_FRAME   = 73
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    // result output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_record_kind,
    output logic [7:0]       o_frame_type,
    output logic [6:0]       o_frame_length,
    output logic [15:0]      o_frame_sequence,
    output logic [7:0]       o_data_byte,
    output logic             o_data_byte_valid,
    output logic             o_run_last,
    output logic [31:0]      o_resyncs,
    output logic [31:0]      o_crc_failures,
    output logic [31:0]      o_unknown_types,
    output logic [31:0]      o_sequence_gaps,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import fprx_pkg::*;

    t_cfg r_cfg;
    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Configuration registers: a write lands at once, unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first       <= RST_SYNC_FIRST;
            r_cfg.sync_second      <= RST_SYNC_SECOND;
            r_cfg.protocol_version <= RST_PROTOCOL_VERSION;
            r_cfg.type_velocity    <= RST_TYPE_VELOCITY;
            r_cfg.type_stop        <= RST_TYPE_STOP;
            r_cfg.type_clear_stop  <= RST_TYPE_CLEAR_STOP;
            r_cfg.type_status      <= RST_TYPE_STATUS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:       r_cfg.sync_first       <= i_cfg_data;
                CFG_SYNC_SECOND:      r_cfg.sync_second      <= i_cfg_data;
                CFG_PROTOCOL_VERSION: r_cfg.protocol_version <= i_cfg_data;
                CFG_TYPE_VELOCITY:    r_cfg.type_velocity    <= i_cfg_data;
                CFG_TYPE_STOP:        r_cfg.type_stop        <= i_cfg_data;
                CFG_TYPE_CLEAR_STOP:  r_cfg.type_clear_stop  <= i_cfg_data;
                CFG_TYPE_STATUS:      r_cfg.type_status      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: parse every byte, check the frame, bump counters, issue one job per byte.
    fprx_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_FRAME   (MAX_FRAME)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .i_full    (full),
        .o_push    (push),
        .o_job     (push_job)
    );

    // Queue: decouple the parser from output stalls and record runs.
    fprx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    // Back: expand each job into its result transactions.
    fprx_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_head            (head_job),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_record_kind     (o_record_kind),
        .o_frame_type      (o_frame_type),
        .o_frame_length    (o_frame_length),
        .o_frame_sequence  (o_frame_sequence),
        .o_data_byte       (o_data_byte),
        .o_data_byte_valid (o_data_byte_valid),
        .o_run_last        (o_run_last),
        .o_resyncs         (o_resyncs),
        .o_crc_failures    (o_crc_failures),
        .o_unknown_types   (o_unknown_types),
        .o_sequence_gaps   (o_sequence_gaps)
    );

endmodule

`default_nettype wire

[src/fprx_front.sv]
// Front part: byte parser, CRC, frame checks, event counters; issues one job per byte.
`default_nettype none

module fprx_front #(
    parameter int MAX_PAYLOAD = 64,
    parameter int MAX_FRAME   = 73
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_rx_byte,
    input  wire fprx_pkg::t_cfg i_cfg,
    input  wire logic           i_full,
    output logic                o_push,
    output fprx_pkg::t_job      o_job
);
    import fprx_pkg::*;

    localparam int BIF_W = $clog2(MAX_FRAME + 2);
    localparam logic [BIF_W-1:0] MAX_FRAME_V = BIF_W'(MAX_FRAME);
    localparam logic [7:0]       MAX_PAY_V   = 8'(MAX_PAYLOAD);

    localparam logic [3:0] PH_SYNC1 = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_VER   = 4'd2;
    localparam logic [3:0] PH_TYPE  = 4'd3;
    localparam logic [3:0] PH_LEN   = 4'd4;
    localparam logic [3:0] PH_SEQL  = 4'd5;
    localparam logic [3:0] PH_SEQH  = 4'd6;
    localparam logic [3:0] PH_PAY   = 4'd7;
    localparam logic [3:0] PH_CRCL  = 4'd8;
    localparam logic [3:0] PH_CRCH  = 4'd9;

    logic [3:0]              r_phase, n_phase;
    logic [7:0]              r_type, n_type;
    logic [6:0]              r_len, n_len;
    logic [15:0]             r_seq, n_seq;
    logic [6:0]              r_pos, n_pos;
    logic [7:0]              r_crc_lo, n_crc_lo;
    logic [15:0]             r_crc, n_crc;
    logic [BIF_W-1:0]        r_bif, n_bif;
    logic [15:0]             r_prev_seq, n_prev_seq;
    logic                    r_prev_seen, n_prev_seen;
    t_counters               r_cnt, n_cnt;
    logic [RUN_MAX-1:0][7:0] r_pay, n_pay;

    logic             fire;
    logic             accept_frame;
    logic             do_reject;
    logic             to_wait;
    logic [BIF_W-1:0] bif_inc;
    logic [15:0]      rx_crc;
    logic             type_known;

    assign o_ready = !i_full;
    assign fire    = i_valid && o_ready;
    assign bif_inc = r_bif + 1'b1;
    assign rx_crc  = {i_rx_byte, r_crc_lo};
    assign type_known = (r_type == i_cfg.type_velocity) || (r_type == i_cfg.type_stop)
                     || (r_type == i_cfg.type_clear_stop);

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_len       = r_len;
        n_seq       = r_seq;
        n_pos       = r_pos;
        n_crc_lo    = r_crc_lo;
        n_crc       = r_crc;
        n_bif       = r_bif;
        n_prev_seq  = r_prev_seq;
        n_prev_seen = r_prev_seen;
        n_cnt       = r_cnt;
        n_pay       = r_pay;
        accept_frame = 1'b0;
        do_reject    = 1'b0;
        to_wait      = 1'b0;
        if (fire) begin
            if (r_phase != PH_SYNC1) begin
                n_bif = bif_inc;
            end
            if (r_phase != PH_SYNC1 && bif_inc > MAX_FRAME_V) begin
                do_reject = 1'b1;
            end else begin
                case (r_phase)
                    PH_SYNC1: begin
                        if (i_rx_byte == i_cfg.sync_first) begin
                            n_phase = PH_SYNC2;
                            n_bif   = BIF_W'(1);
                        end
                    end
                    PH_SYNC2: begin
                        if (i_rx_byte == i_cfg.sync_second) begin
                            n_phase = PH_VER;
                        end else begin
                            to_wait = 1'b1;
                        end
                    end
                    PH_VER: begin
                        if (i_rx_byte != i_cfg.protocol_version) begin
                            do_reject = 1'b1;
                        end else begin
                            n_crc   = crc16_byte(CRC_INIT, i_rx_byte);
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_type  = i_rx_byte;
                        n_crc   = crc16_byte(r_crc, i_rx_byte);
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (i_rx_byte > MAX_PAY_V) begin
                            do_reject = 1'b1;
                        end else begin
                            n_len   = i_rx_byte[6:0];
                            n_crc   = crc16_byte(r_crc, i_rx_byte);
                            n_phase = PH_SEQL;
                        end
                    end
                    PH_SEQL: begin
                        n_seq   = {8'h00, i_rx_byte};
                        n_crc   = crc16_byte(r_crc, i_rx_byte);
                        n_phase = PH_SEQH;
                    end
                    PH_SEQH: begin
                        n_seq   = {i_rx_byte, r_seq[7:0]};
                        n_crc   = crc16_byte(r_crc, i_rx_byte);
                        n_pos   = 7'd0;
                        n_phase = (r_len == 7'd0) ? PH_CRCL : PH_PAY;
                    end
                    PH_PAY: begin
                        if (r_pos >= r_len) begin
                            do_reject = 1'b1;
                        end else begin
                            // only the first bytes can ever be played out
                            if (r_pos < 7'(RUN_MAX)) begin
                                n_pay[r_pos[RUN_IDX_W-1:0]] = i_rx_byte;
                            end
                            n_crc = crc16_byte(r_crc, i_rx_byte);
                            n_pos = r_pos + 7'd1;
                            if (r_pos + 7'd1 >= r_len) begin
                                n_phase = PH_CRCL;
                            end
                        end
                    end
                    PH_CRCL: begin
                        n_crc_lo = i_rx_byte;
                        n_phase  = PH_CRCH;
                    end
                    PH_CRCH: begin
                        if (r_crc != rx_crc) begin
                            n_cnt.crc_failures = r_cnt.crc_failures + 32'd1;
                            do_reject = 1'b1;
                        end else if (r_type == i_cfg.type_status) begin
                            do_reject = 1'b1;
                        end else if (!type_known) begin
                            n_cnt.unknown_types = r_cnt.unknown_types + 32'd1;
                            do_reject = 1'b1;
                        end else if (r_type == i_cfg.type_velocity) begin
                            if (r_len != VEL_LEN) begin
                                do_reject = 1'b1;
                            end else begin
                                if (r_prev_seen && r_seq != r_prev_seq + 16'd1) begin
                                    n_cnt.sequence_gaps = r_cnt.sequence_gaps + 32'd1;
                                end
                                n_prev_seq   = r_seq;
                                n_prev_seen  = 1'b1;
                                accept_frame = 1'b1;
                                to_wait      = 1'b1;
                            end
                        end else if (r_len != 7'd0) begin
                            do_reject = 1'b1;
                        end else begin
                            accept_frame = 1'b1;
                            to_wait      = 1'b1;
                        end
                    end
                    default: begin
                        to_wait = 1'b1;
                    end
                endcase
            end
            if (do_reject) begin
                n_cnt.resyncs = r_cnt.resyncs + 32'd1;
            end
            if (do_reject || to_wait) begin
                n_phase  = PH_SYNC1;
                n_pos    = 7'd0;
                n_crc_lo = 8'h00;
                n_bif    = '0;
                n_crc    = CRC_INIT;
            end
        end
    end

    always_comb begin
        o_push        = fire;
        o_job.kind    = accept_frame;
        o_job.ftype   = accept_frame ? r_type : 8'h00;
        o_job.flen    = accept_frame ? r_len : 7'd0;
        o_job.fseq    = accept_frame ? r_seq : 16'h0000;
        o_job.payload = r_pay;
        o_job.cnt     = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_type      <= 8'h00;
            r_len       <= 7'd0;
            r_seq       <= 16'h0000;
            r_pos       <= 7'd0;
            r_crc_lo    <= 8'h00;
            r_crc       <= CRC_INIT;
            r_bif       <= '0;
            r_prev_seq  <= 16'h0000;
            r_prev_seen <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_len       <= n_len;
            r_seq       <= n_seq;
            r_pos       <= n_pos;
            r_crc_lo    <= n_crc_lo;
            r_crc       <= n_crc;
            r_bif       <= n_bif;
            r_prev_seq  <= n_prev_seq;
            r_prev_seen <= n_prev_seen;
            r_cnt       <= n_cnt;
        end
    end

    // payload bytes: no reset, every byte played out is written in its own frame
    always_ff @(posedge i_clk) begin
        r_pay <= n_pay;
    end

endmodule

`default_nettype wire

[src/fprx_queue.sv]
// Short job queue between the parser front and the record back end.
`default_nettype none

module fprx_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire fprx_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output fprx_pkg::t_job      o_head
);
    import fprx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[src/fprx_back.sv]
// Back part: plays each queued job out as one status result or a run of frame records.
`default_nettype none

module fprx_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire fprx_pkg::t_job i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_record_kind,
    output logic [7:0]          o_frame_type,
    output logic [6:0]          o_frame_length,
    output logic [15:0]         o_frame_sequence,
    output logic [7:0]          o_data_byte,
    output logic                o_data_byte_valid,
    output logic                o_run_last,
    output logic [31:0]         o_resyncs,
    output logic [31:0]         o_crc_failures,
    output logic [31:0]         o_unknown_types,
    output logic [31:0]         o_sequence_gaps
);
    import fprx_pkg::*;

    logic [RUN_IDX_W-1:0] r_idx;
    logic                 has_data;
    logic                 last;

    assign has_data = i_head.kind && (i_head.flen != 7'd0);
    assign last     = !has_data || (7'(r_idx) + 7'd1 == i_head.flen);

    assign o_valid           = !i_empty;
    assign o_pop             = o_valid && i_ready && last;
    assign o_record_kind     = i_head.kind;
    assign o_frame_type      = i_head.ftype;
    assign o_frame_length    = i_head.flen;
    assign o_frame_sequence  = i_head.fseq;
    assign o_data_byte       = has_data ? i_head.payload[r_idx] : 8'h00;
    assign o_data_byte_valid = has_data;
    assign o_run_last        = last;
    assign o_resyncs         = i_head.cnt.resyncs;
    assign o_crc_failures    = i_head.cnt.crc_failures;
    assign o_unknown_types   = i_head.cnt.unknown_types;
    assign o_sequence_gaps   = i_head.cnt.sequence_gaps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_idx <= last ? '0 : r_idx + 1'b1;
        end
    end

endmodule

`default_nettype wire

[src/fprx_checker.sv]
// Port-level assertions for the framed packet receiver, bound to its top level.
`default_nettype none

module fprx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_record_kind,
    input wire logic [7:0]  o_frame_type,
    input wire logic [6:0]  o_frame_length,
    input wire logic [15:0] o_frame_sequence,
    input wire logic [7:0]  o_data_byte,
    input wire logic        o_data_byte_valid,
    input wire logic        o_run_last
);

    // A stalled result transaction holds its sequence, data byte and run-last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_sequence)
            && $stable(o_data_byte) && $stable(o_run_last))
        else $error("result changed while stalled");

    // Reset empties the queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A status result is a single transaction without header or payload.
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_record_kind |-> o_run_last && !o_data_byte_valid
            && o_frame_type == 8'h00 && o_frame_length == 7'd0)
        else $error("malformed status result");

    // Inside a record run the next record follows at once, same frame.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_run_last |=> o_valid && o_record_kind
            && $stable(o_frame_sequence) && $stable(o_frame_type))
        else $error("record run broken");

    // Payload bytes only come with frame records of nonzero length.
    a_data_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data_byte_valid |-> o_record_kind && o_frame_length != 7'd0)
        else $error("payload byte outside a frame record");

endmodule

bind framed_packet_receiver_crc16 fprx_checker u_fprx_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_record_kind     (o_record_kind),
    .o_frame_type      (o_frame_type),
    .o_frame_length    (o_frame_length),
    .o_frame_sequence  (o_frame_sequence),
    .o_data_byte       (o_data_byte),
    .o_data_byte_valid (o_data_byte_valid),
    .o_run_last        (o_run_last)
);

`default_nettype wire
